// ----- hdl/bfr_pkg.sv -----
// bfr_pkg: shared types, result kind codes and crc helper for the bit-stuffed frame receiver
// no dependencies

package bfr_pkg;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_BYTE      = 2'd0;
	localparam kind_t KIND_COLLISION = 2'd1;
	localparam kind_t KIND_IDLE      = 2'd2;

	localparam logic [7:0] CRC_POLY = 8'h8C;
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [5:0] IDLE_LIMIT_RESET = 6'd32;
	localparam logic [5:0] IDLE_LIMIT_MIN = 6'd8;
	localparam logic [5:0] RUN_RESET = 6'd4;
	localparam logic [5:0] RUN_DATA_MAX = 6'd4;
	localparam logic [5:0] RUN_FRAME_END = 6'd5;
	localparam logic [5:0] RUN_RESYNC = 6'd8;
	localparam logic [5:0] RUN_AFTER_IDLE = 6'd8;
	localparam logic [4:0] HDR_BYTES = 5'd3;
	localparam logic [3:0] LEN_MASK = 4'hF;

	localparam int CFG_AW = 2;
	localparam logic [CFG_AW-1:0] REG_IDLE_LIMIT = 2'd0;

	// reflected crc-8, one byte, bit by bit
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

// ----- hdl/bitstuffed_frame_receiver_unit.sv -----
// bitstuffed_frame_receiver_unit: bit-stuffed frame receiver with frame store, crc check
// and result sequencer; depends on bfr_pkg

// One bus sample is taken per transaction. A sample that causes no result leaves the input
// ready, and the next can follow at once. A sample with a collision or idle timeout holds
// the input while the sequencer passes its collision and timeout states. A frame end reads
// byte 1 for the length and, if enough bits came in, walks the frame store once for the crc
// (3+len bytes, one byte per cycle through the single read port of the store); if the crc
// checks, it walks it again to deliver the 2+len message bytes, one per cycle while the
// output is taken. Output stalls hold the sequencer. The output register lets the next
// sample be taken while the last result still waits.

module bitstuffed_frame_receiver_unit #(
	parameter int FRAME_BYTES = 18
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        line_level,
	input  logic                        tx_active,
	input  logic                        tx_level,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  kind,
	output logic [7:0]                  data_byte,
	output logic [4:0]                  byte_index,
	output logic                        last,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bfr_pkg::CFG_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int AW = $clog2(FRAME_BYTES);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LEN  = 3'd1;
	localparam logic [2:0] S_CRC  = 3'd2;
	localparam logic [2:0] S_COLL = 3'd3;
	localparam logic [2:0] S_BRD  = 3'd4;
	localparam logic [2:0] S_BOUT = 3'd5;
	localparam logic [2:0] S_TOUT = 3'd6;

	logic [2:0] state_q, state_d;

	logic [5:0] idle_limit_q;
	logic [5:0] run_count_q;
	logic       last_level_q;
	logic [7:0] bit_count_q;
	logic [7:0] shift_q;
	logic [7:0] bc_old_q;
	logic       coll_q;
	logic       idle_q;
	logic       msg_ok_q;
	logic [4:0] need_q;
	logic [4:0] idx_q;
	logic [7:0] crc_q;

	logic [7:0] frame_store [FRAME_BYTES];
	logic [7:0] rdata_q;
	logic [AW-1:0] raddr;
	logic       mem_we;

	logic       out_valid_q;
	bfr_pkg::kind_t kind_q;
	logic [7:0] data_q;
	logic [4:0] index_q;
	logic       last_q;

	logic       accept;
	logic       out_free;
	logic [5:0] limit;
	logic       is_data;
	logic       is_end;
	logic       is_resync;
	logic       ev_coll;
	logic       ev_idle;
	logic [7:0] shift_next;
	logic [7:0] bc_next;
	logic [5:0] run_next;
	logic [3:0] len;
	logic [4:0] need;
	logic [7:0] crc_next;
	logic       cfg_wr;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign data_byte = data_q;
	assign byte_index = index_q;
	assign last      = last_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == bfr_pkg::REG_IDLE_LIMIT);
	assign prdata = (paddr == bfr_pkg::REG_IDLE_LIMIT) ? {26'd0, idle_limit_q} : 32'd0;

	// sample decode
	assign limit = (idle_limit_q < bfr_pkg::IDLE_LIMIT_MIN) ? bfr_pkg::IDLE_LIMIT_MIN
		: idle_limit_q;
	assign is_data   = run_count_q < bfr_pkg::RUN_DATA_MAX;
	assign is_end    = !is_data && line_level && (run_count_q == bfr_pkg::RUN_FRAME_END);
	assign is_resync = !is_data && line_level && (run_count_q == bfr_pkg::RUN_RESYNC);
	assign ev_coll   = tx_active && (line_level != tx_level);
	assign ev_idle   = (line_level == last_level_q) && (run_count_q >= limit);
	assign shift_next = {shift_q[6:0], line_level};
	assign mem_we = accept && is_data && (bit_count_q[2:0] == 3'd7)
		&& ({1'b0, bit_count_q[7:3]} < 6'(FRAME_BYTES));

	always_comb begin
		if (ev_idle)
			bc_next = 8'd0;
		else if (is_end || is_resync)
			bc_next = 8'd0;
		else if (is_data && bit_count_q != 8'hFF)
			bc_next = bit_count_q + 8'd1;
		else
			bc_next = bit_count_q;
	end

	always_comb begin
		if (line_level != last_level_q)
			run_next = 6'd0;
		else if (ev_idle)
			run_next = bfr_pkg::RUN_AFTER_IDLE;
		else
			run_next = run_count_q + 6'd1;
	end

	assign len      = rdata_q[3:0] & bfr_pkg::LEN_MASK;
	assign need     = bfr_pkg::HDR_BYTES + {1'b0, len};
	assign crc_next = bfr_pkg::crc8_byte(crc_q, rdata_q);

	// store read address for the next cycle
	always_comb begin
		unique case (state_q)
			S_IDLE:  raddr = AW'(1);
			S_LEN:   raddr = '0;
			S_CRC:   raddr = AW'(idx_q + 5'd1);
			S_BRD:   raddr = AW'(idx_q);
			S_BOUT:  raddr = out_free ? AW'(idx_q + 5'd1) : AW'(idx_q);
			default: raddr = AW'(idx_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			frame_store[AW'(bit_count_q[7:3])] <= shift_next;
		rdata_q <= frame_store[raddr];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_end)
						state_d = S_LEN;
					else if (ev_coll || ev_idle)
						state_d = S_COLL;
				end
			end
			S_LEN: begin
				if (bc_old_q >= {need, 3'b000})
					state_d = S_CRC;
				else
					state_d = S_COLL;
			end
			S_CRC: begin
				if (idx_q == need_q - 5'd1)
					state_d = S_COLL;
			end
			S_COLL: begin
				if (!coll_q || out_free)
					state_d = msg_ok_q ? S_BRD : S_TOUT;
			end
			S_BRD: state_d = S_BOUT;
			S_BOUT: begin
				if (out_free && idx_q == need_q - 5'd2)
					state_d = S_TOUT;
			end
			S_TOUT: begin
				if (!idle_q || out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idle_limit_q <= bfr_pkg::IDLE_LIMIT_RESET;
			run_count_q  <= bfr_pkg::RUN_RESET;
			last_level_q <= 1'b1;
			bit_count_q  <= 8'd0;
			shift_q      <= 8'd0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr)
				idle_limit_q <= pwdata[5:0];
			if (accept) begin
				run_count_q <= run_next;
				last_level_q <= line_level;
				bit_count_q <= bc_next;
				if (is_data)
					shift_q <= shift_next;
			end
			if (out_ready)
				out_valid_q <= 1'b0;
			if ((state_q == S_COLL && coll_q && out_free)
				|| (state_q == S_BOUT && out_free)
				|| (state_q == S_TOUT && idle_q && out_free))
				out_valid_q <= 1'b1;
		end
	end

	// sequencer payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			coll_q   <= ev_coll;
			idle_q   <= ev_idle;
			msg_ok_q <= 1'b0;
			bc_old_q <= bit_count_q;
		end
		unique case (state_q)
			S_LEN: begin
				need_q <= need;
				idx_q  <= 5'd0;
				crc_q  <= bfr_pkg::CRC_INIT;
			end
			S_CRC: begin
				crc_q <= crc_next;
				if (idx_q == need_q - 5'd1) begin
					msg_ok_q <= (crc_next == 8'd0);
					idx_q    <= 5'd0;
				end else begin
					idx_q <= idx_q + 5'd1;
				end
			end
			S_COLL: begin
				if (coll_q && out_free) begin
					kind_q  <= bfr_pkg::KIND_COLLISION;
					data_q  <= 8'd0;
					index_q <= 5'd0;
					last_q  <= !msg_ok_q && !idle_q;
				end
			end
			S_BOUT: begin
				if (out_free) begin
					kind_q  <= bfr_pkg::KIND_BYTE;
					data_q  <= rdata_q;
					index_q <= idx_q;
					last_q  <= (idx_q == need_q - 5'd2) && !idle_q;
					idx_q   <= idx_q + 5'd1;
				end
			end
			S_TOUT: begin
				if (idle_q && out_free) begin
					kind_q  <= bfr_pkg::KIND_IDLE;
					data_q  <= 8'd0;
					index_q <= 5'd0;
					last_q  <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
